### design/b64d_pkg.sv
// Shared types and the character classifier for the base64 stream decoder.
// No dependencies; imported by every module of the decoder.
`default_nettype none
package b64d_pkg;

  localparam int unsigned CountW = 24;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [7:0] PadChar = 8'd61;
  localparam logic [5:0] SextetPlus = 6'd62;
  localparam logic [5:0] SextetSlash = 6'd63;
  localparam logic [5:0] LowerBase = 6'd26;
  localparam logic [5:0] DigitBase = 6'd52;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } b64d_kind_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_message;
  } b64d_in_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              kind;
    logic              decode_ok;
    logic [CountW-1:0] total_bytes;
    logic              last_of_run;
  } b64d_out_t;

  // All results caused by one request: up to three bytes, then an optional status.
  typedef struct packed {
    logic [23:0]       quad;
    logic [1:0]        nbytes;
    logic              status;
    logic              ok;
    logic [CountW-1:0] total;
  } b64d_bundle_t;

  typedef struct packed {
    logic       alpha;
    logic       pad;
    logic [5:0] sextet;
  } b64d_class_t;

  function automatic b64d_class_t classify(input logic [7:0] c);
    b64d_class_t r;
    r = '0;
    if (c >= 8'd65 && c <= 8'd90) begin
      r.alpha  = 1'b1;
      r.sextet = 6'(c - 8'd65);
    end else if (c >= 8'd97 && c <= 8'd122) begin
      r.alpha  = 1'b1;
      r.sextet = LowerBase + 6'(c - 8'd97);
    end else if (c >= 8'd48 && c <= 8'd57) begin
      r.alpha  = 1'b1;
      r.sextet = DigitBase + 6'(c - 8'd48);
    end else if (c == 8'd43) begin
      r.alpha  = 1'b1;
      r.sextet = SextetPlus;
    end else if (c == 8'd47) begin
      r.alpha  = 1'b1;
      r.sextet = SextetSlash;
    end else if (c == PadChar) begin
      r.pad = 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### design/b64d_core.sv
// Input register, quad accumulator and decode state for the base64 decoder.
// Depends on b64d_pkg; hands at most one result bundle per request to b64d_outq.
`default_nettype none
module b64d_core (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  char_valid,
  output logic                       char_ready,
  input  wire b64d_pkg::b64d_in_t    char_item,
  output b64d_pkg::b64d_bundle_t     bndl,
  output logic                       bndl_push,
  input  wire logic                  bndl_full
);
  import b64d_pkg::*;

  logic              in_valid_q;
  b64d_in_t          in_q;
  logic [23:0]       quad_accum;
  logic [1:0]        quad_position;
  logic              expect_second_pad;
  logic              error_seen;
  logic [CountW-1:0] byte_count;

  b64d_class_t       cls;
  logic [23:0]       acc_ins;
  logic [23:0]       acc_next;
  logic [1:0]        pos_next;
  logic              exp_next;
  logic              err_next;
  logic [1:0]        nbytes;
  logic [23:0]       emit_acc;
  logic [CountW:0]   count_sum;
  logic [CountW-1:0] count_emit;
  logic              push_needed;
  logic              fire;

  assign cls = classify(in_q.char_code);

  always_comb begin
    case (quad_position)
      2'd0:    acc_ins = quad_accum | {cls.sextet, 18'd0};
      2'd1:    acc_ins = quad_accum | {6'd0, cls.sextet, 12'd0};
      2'd2:    acc_ins = quad_accum | {12'd0, cls.sextet, 6'd0};
      default: acc_ins = quad_accum | {18'd0, cls.sextet};
    endcase
  end

  always_comb begin
    acc_next = quad_accum;
    pos_next = quad_position;
    exp_next = expect_second_pad;
    err_next = error_seen;
    nbytes   = 2'd0;
    emit_acc = quad_accum;
    if (!error_seen) begin
      if (expect_second_pad) begin
        if (cls.pad) begin
          nbytes = 2'd1;
        end else begin
          err_next = 1'b1;
        end
      end else if (cls.alpha) begin
        acc_next = acc_ins;
        emit_acc = acc_ins;
        if (quad_position == 2'd3) begin
          nbytes = 2'd3;
        end else begin
          pos_next = quad_position + 2'd1;
        end
      end else if (cls.pad) begin
        if (quad_position == 2'd2) begin
          exp_next = 1'b1;
          pos_next = 2'd3;
        end else if (quad_position == 2'd3) begin
          nbytes = 2'd2;
        end else begin
          err_next = 1'b1;
        end
      end else begin
        err_next = 1'b1;
      end
    end
    if (nbytes != 2'd0) begin
      acc_next = '0;
      pos_next = 2'd0;
      exp_next = 1'b0;
    end
    if (in_q.end_of_message && !err_next) begin
      if (exp_next) begin
        nbytes = 2'd1;
      end else if (pos_next == 2'd1) begin
        err_next = 1'b1;
      end else if (pos_next == 2'd2) begin
        nbytes = 2'd1;
      end else if (pos_next == 2'd3) begin
        nbytes = 2'd2;
      end
    end
  end

  assign count_sum  = {1'b0, byte_count} + {{(CountW - 1){1'b0}}, nbytes};
  assign count_emit = count_sum[CountW] ? CountMax : count_sum[CountW-1:0];

  always_comb begin
    bndl.quad   = emit_acc;
    bndl.nbytes = nbytes;
    bndl.status = in_q.end_of_message;
    bndl.ok     = !err_next;
    bndl.total  = err_next ? '0 : count_emit;
  end

  assign push_needed = (nbytes != 2'd0) || in_q.end_of_message;
  assign fire        = in_valid_q && !(push_needed && bndl_full);
  assign bndl_push   = fire && push_needed;
  assign char_ready  = !in_valid_q || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q        <= 1'b0;
      quad_accum        <= '0;
      quad_position     <= 2'd0;
      expect_second_pad <= 1'b0;
      error_seen        <= 1'b0;
      byte_count        <= '0;
    end else begin
      if (char_ready) begin
        in_valid_q <= char_valid;
      end
      if (fire) begin
        if (in_q.end_of_message) begin
          quad_accum        <= '0;
          quad_position     <= 2'd0;
          expect_second_pad <= 1'b0;
          error_seen        <= 1'b0;
          byte_count        <= '0;
        end else begin
          quad_accum        <= acc_next;
          quad_position     <= pos_next;
          expect_second_pad <= exp_next;
          error_seen        <= err_next;
          byte_count        <= count_emit;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (char_ready && char_valid) begin
      in_q <= char_item;
    end
  end

endmodule
`default_nettype wire

### design/b64d_outq.sv
// Two-entry result bundle queue and serializer for the base64 decoder.
// Depends on b64d_pkg; emits one result per cycle from the head bundle while res_ready is high.
`default_nettype none
module b64d_outq (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire b64d_pkg::b64d_bundle_t bndl,
  input  wire logic                   bndl_push,
  output logic                        bndl_full,
  output logic                        res_valid,
  input  wire logic                   res_ready,
  output b64d_pkg::b64d_out_t         res_item
);
  import b64d_pkg::*;

  b64d_bundle_t entries [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic [1:0]   idx;

  b64d_bundle_t head;
  logic [2:0]   n_results;
  logic         last;
  logic         pop;

  assign head      = entries[rd_ptr];
  assign n_results = {1'b0, head.nbytes} + {2'b00, head.status};
  assign last      = ({1'b0, idx} == (n_results - 3'd1));
  assign res_valid = (count != 2'd0);
  assign bndl_full = (count == 2'd2);
  assign pop       = res_valid && res_ready && last;

  always_comb begin
    res_item             = '0;
    res_item.last_of_run = last;
    if (idx < head.nbytes) begin
      res_item.kind = KIND_DATA;
      case (idx)
        2'd0:    res_item.out_byte = head.quad[23:16];
        2'd1:    res_item.out_byte = head.quad[15:8];
        2'd2:    res_item.out_byte = head.quad[7:0];
        default: res_item.out_byte = '0;
      endcase
    end else begin
      res_item.kind        = KIND_STATUS;
      res_item.decode_ok   = head.ok;
      res_item.total_bytes = head.total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
      idx    <= 2'd0;
    end else begin
      if (bndl_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (res_valid && res_ready) begin
        if (last) begin
          idx    <= 2'd0;
          rd_ptr <= !rd_ptr;
        end else begin
          idx <= idx + 2'd1;
        end
      end
      count <= count + {1'b0, bndl_push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (bndl_push) begin
      entries[wr_ptr] <= bndl;
    end
  end

endmodule
`default_nettype wire

### design/base64_stream_decoder.sv
// Base64 stream decoder: a character and a result per cycle unless stalled.
// With the result queue empty, a request passes the input register and then
// the result queue before its first result is valid.
// Throughput: one character per cycle; the queue drains one result per cycle
// if res_ready is high; only a push onto two queued bundles stalls input.
// Reset: synchronous, clears decode state, input register and result queue.
// Depends on b64d_pkg, b64d_core and b64d_outq.
`default_nettype none
module base64_stream_decoder (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                char_valid,
  output logic                     char_ready,
  input  wire b64d_pkg::b64d_in_t  char_item,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output b64d_pkg::b64d_out_t      res_item
);
  import b64d_pkg::*;

  b64d_bundle_t bndl;
  logic         bndl_push;
  logic         bndl_full;

  b64d_core u_core (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item),
    .bndl       (bndl),
    .bndl_push  (bndl_push),
    .bndl_full  (bndl_full)
  );

  b64d_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .bndl      (bndl),
    .bndl_push (bndl_push),
    .bndl_full (bndl_full),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

endmodule
`default_nettype wire

### design/b64d_checker.sv
// Port-level checks for base64_stream_decoder, attached by bind.
// Depends on b64d_pkg.
`default_nettype none
module b64d_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                char_valid,
  input wire logic                char_ready,
  input wire b64d_pkg::b64d_in_t  char_item,
  input wire logic                res_valid,
  input wire logic                res_ready,
  input wire b64d_pkg::b64d_out_t res_item
);
  import b64d_pkg::*;

  logic unused_in;
  assign unused_in = char_valid ^ char_ready ^ (^char_item);

  a_idle_after_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_item))
    else $error("stalled result changed");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.kind == KIND_STATUS |-> res_item.last_of_run)
    else $error("status is not last of its run");

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.kind == KIND_DATA |->
      !res_item.decode_ok && res_item.total_bytes == '0)
    else $error("data result carries status fields");

  a_error_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.kind == KIND_STATUS && !res_item.decode_ok |->
      res_item.total_bytes == '0)
    else $error("error status with nonzero count");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (.*);
`default_nettype wire

### test/base64_stream_decoder_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for base64_stream_decoder: directed and random messages
// against an internal decode predictor. Depends on b64d_pkg and the decoder RTL.
module base64_stream_decoder_tb;
  import b64d_pkg::*;

  localparam int PadCode = 64;
  localparam int BadCode = 65;
  localparam int RandomItems = 254;
  localparam int MaxShown = 10;

  typedef struct {
    b64d_in_t item;
    int       phase;
  } char_req_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      char_valid = 1'b0;
  logic      char_ready;
  b64d_in_t  char_item = '0;
  logic      res_valid;
  logic      res_ready = 1'b0;
  b64d_out_t res_item;

  char_req_t   char_stream[$];
  char_req_t   next_req;
  b64d_out_t   decoded_q[$];
  b64d_out_t   run_q[$];
  logic [7:0]  msg[$];
  int          drive_phase = 0;
  int          mismatch_count = 0;
  int          directed_count;

  logic [23:0] quad_acc = '0;
  logic [1:0]  quad_pos = '0;
  logic        want_pad = 1'b0;
  logic        err_seen = 1'b0;
  logic [23:0] byte_total = '0;

  base64_stream_decoder u_dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_item   (res_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int char_code_of(input logic [7:0] c);
    if (c inside {[8'd65:8'd90]}) return int'(c) - 65;
    if (c inside {[8'd97:8'd122]}) return int'(c) - 71;
    if (c inside {[8'd48:8'd57]}) return int'(c) + 4;
    case (c)
      8'd43:   return 62;
      8'd47:   return 63;
      PadChar: return PadCode;
      default: return BadCode;
    endcase
  endfunction

  function automatic logic [7:0] sextet_char(input logic [5:0] s);
    if (s < 6'd26) return 8'd65 + 8'(s);
    if (s < 6'd52) return 8'd71 + 8'(s);
    if (s < 6'd62) return 8'(s) - 8'd4;
    return (s == 6'd62) ? 8'd43 : 8'd47;
  endfunction

  function automatic void flush_quad(input int n);
    b64d_out_t r;
    for (int i = 0; i < n; i++) begin
      r = '0;
      r.out_byte = quad_acc[23-8*i -: 8];
      r.kind = KIND_DATA;
      run_q.push_back(r);
      if (byte_total != CountMax) byte_total++;
    end
    quad_acc = '0;
    quad_pos = '0;
    want_pad = 1'b0;
  endfunction

  function automatic void decode_char_request(input b64d_in_t req);
    int        code;
    b64d_out_t status;
    code = char_code_of(req.char_code);
    run_q.delete();
    if (!err_seen) begin
      if (want_pad) begin
        if (code == PadCode) flush_quad(1);
        else err_seen = 1'b1;
      end else if (code < PadCode) begin
        quad_acc[23-6*quad_pos -: 6] = code[5:0];
        if (quad_pos == 2'd3) flush_quad(3);
        else quad_pos++;
      end else if (code == PadCode) begin
        if (quad_pos == 2'd2) begin
          want_pad = 1'b1;
          quad_pos = 2'd3;
        end else if (quad_pos == 2'd3) begin
          flush_quad(2);
        end else begin
          err_seen = 1'b1;
        end
      end else begin
        err_seen = 1'b1;
      end
    end
    if (req.end_of_message) begin
      if (!err_seen) begin
        if (want_pad) flush_quad(1);
        else if (quad_pos == 2'd1) err_seen = 1'b1;
        else if (quad_pos == 2'd2) flush_quad(1);
        else if (quad_pos == 2'd3) flush_quad(2);
      end
      status = '0;
      status.kind = KIND_STATUS;
      status.decode_ok = !err_seen;
      status.total_bytes = err_seen ? '0 : byte_total;
      run_q.push_back(status);
      quad_acc = '0;
      quad_pos = '0;
      want_pad = 1'b0;
      err_seen = 1'b0;
      byte_total = '0;
    end
    if (run_q.size() != 0) run_q[$].last_of_run = 1'b1;
    foreach (run_q[i]) decoded_q.push_back(run_q[i]);
  endfunction

  function automatic void note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MaxShown) $display("%0t mismatch: %s", $realtime, what);
  endfunction

  function automatic void check_result(input b64d_out_t got);
    b64d_out_t want;
    if (decoded_q.size() == 0) begin
      note_mismatch($sformatf("unexpected result byte=%h kind=%0d ok=%0d total=%0d last=%0d",
                              got.out_byte, got.kind, got.decode_ok, got.total_bytes,
                              got.last_of_run));
      return;
    end
    want = decoded_q.pop_front();
    if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
        got.decode_ok !== want.decode_ok || got.total_bytes !== want.total_bytes ||
        got.last_of_run !== want.last_of_run)
      note_mismatch($sformatf({"expected byte=%h kind=%0d ok=%0d total=%0d last=%0d, ",
                               "got byte=%h kind=%0d ok=%0d total=%0d last=%0d"},
                              want.out_byte, want.kind, want.decode_ok, want.total_bytes,
                              want.last_of_run, got.out_byte, got.kind, got.decode_ok,
                              got.total_bytes, got.last_of_run));
  endfunction

  function automatic int send_idle_pct(input int phase);
    case (phase)
      0:       return 34;
      1:       return 67;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_idle_pct(input int phase);
    case (phase)
      0:       return 67;
      1:       return 34;
      default: return 0;
    endcase
  endfunction

  function automatic void push_message();
    char_req_t r;
    foreach (msg[i]) begin
      r.item.char_code = msg[i];
      r.item.end_of_message = (i == msg.size() - 1);
      r.phase = 0;
      char_stream.push_back(r);
    end
    msg.delete();
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
    push_message();
  endfunction

  function automatic void add_alpha(input int n);
    for (int i = 0; i < n; i++) msg.push_back(sextet_char(6'($urandom_range(0, 63))));
  endfunction

  function automatic void add_random_message();
    int groups;
    int pick;
    int at;
    groups = $urandom_range(0, 3);
    for (int g = 0; g < groups; g++) begin
      pick = $urandom_range(0, 7);
      if (pick <= 5) begin
        add_alpha(4);
      end else if (pick == 6) begin
        add_alpha(3);
        msg.push_back(PadChar);
      end else begin
        add_alpha(2);
        msg.push_back(PadChar);
        msg.push_back(PadChar);
      end
    end
    case ($urandom_range(0, 3))
      1: add_alpha(2);
      2: add_alpha(3);
      3: begin
        add_alpha(2);
        msg.push_back(PadChar);
      end
      default: ;
    endcase
    if (msg.size() == 0) add_alpha(4);
    if ($urandom_range(0, 4) == 0) begin
      at = $urandom_range(0, msg.size() - 1);
      case ($urandom_range(0, 2))
        0: msg[at] = 8'($urandom_range(0, 255));
        1: msg.insert(at, PadChar);
        default: add_alpha(1);
      endcase
    end
    push_message();
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (!char_valid || char_ready) begin
      if (char_valid) decode_char_request(char_item);
      if (char_stream.size() != 0 &&
          $urandom_range(0, 99) >= send_idle_pct(char_stream[0].phase)) begin
        next_req = char_stream.pop_front();
        char_item <= next_req.item;
        char_valid <= 1'b1;
        drive_phase <= next_req.phase;
      end else begin
        char_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) check_result(res_item);
      res_ready <= ($urandom_range(0, 99) >= recv_idle_pct(drive_phase));
    end
  end

  initial begin
    add_text("A/z9");
    add_text("QUI=QQ");
    add_text("QUJ");
    add_text("QQ=");
    add_text("Q");
    add_text("=");
    add_text("Q=");
    add_text("QQ=A");
    msg = '{8'hFF, 8'h00};
    push_message();
    directed_count = char_stream.size();
    while (char_stream.size() < directed_count + RandomItems) add_random_message();
    foreach (char_stream[i]) char_stream[i].phase = (i * 3) / char_stream.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (char_stream.size() != 0 || char_valid) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && decoded_q.size() == 0) begin
      $display("base64_stream_decoder regression: pass");
    end else begin
      $display("base64_stream_decoder regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("base64_stream_decoder regression: fail");
    $finish;
  end

endmodule

### filelist.f
design/b64d_pkg.sv
design/b64d_core.sv
design/b64d_outq.sv
design/base64_stream_decoder.sv
design/b64d_checker.sv
test/base64_stream_decoder_tb.sv
